[rtl/wec_pkg.sv]
// ----------------------------------------------------------------------------
// wec_pkg
// Shared types, widths and constants of the wrench offset/EMA conditioner.
// ----------------------------------------------------------------------------
package wec_pkg;

	// Number of force/torque channels and their order.
	localparam int NCH   = 6;
	localparam int CH_FX = 0;
	localparam int CH_FY = 1;
	localparam int CH_FZ = 2;
	localparam int CH_TX = 3;
	localparam int CH_TY = 4;
	localparam int CH_TZ = 5;

	// Sample width and calibration length.
	localparam int SAMPLE_BITS = 16;
	localparam int CAL_SAMPLES = 100;

	// Fixed-point format of the filter weight and state.
	localparam int FRAC_BITS = 16;
	localparam int ALPHA_W   = FRAC_BITS + 1;

	// A remapped sample may be the negated most negative raw value.
	localparam int REMAP_W = SAMPLE_BITS + 1;
	localparam int OFS_W   = SAMPLE_BITS + 1;
	localparam int ADJ_W   = SAMPLE_BITS + 2;
	localparam int FILT_W  = ADJ_W + FRAC_BITS;
	localparam int DIFF_W  = FILT_W + 1;
	localparam int PROD_W  = DIFF_W + ALPHA_W + 1;
	localparam int OUT_W   = FILT_W - FRAC_BITS;

	// Calibration counter and running sum.
	localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
	localparam int SUM_W = REMAP_W + CNT_W;

	// Division of the sum magnitude by CAL_SAMPLES as a reciprocal multiply.
	// The shift is wide enough that the rounded-up reciprocal is exact for
	// every magnitude the sum can reach.
	localparam int ABS_W     = SUM_W - 1;
	localparam int DIV_SHIFT = ABS_W + CNT_W;
	localparam int MUL_W     = DIV_SHIFT + 1;
	localparam int DPROD_W   = ABS_W + MUL_W;
	localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'(((longint'(1) << DIV_SHIFT)
		+ longint'(CAL_SAMPLES) - longint'(1)) / longint'(CAL_SAMPLES));

	localparam logic [ALPHA_W-1:0] ONE_Q16 = ALPHA_W'(1) << FRAC_BITS;

	// Input opcodes.
	typedef enum logic {
		OP_SAMPLE    = 1'b0,
		OP_CAL_START = 1'b1
	} opcode_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [REMAP_W-1:0]     remap_t;
	typedef logic signed [OFS_W-1:0]       ofs_t;
	typedef logic signed [FILT_W-1:0]      filt_t;
	typedef logic signed [OUT_W-1:0]       out_t;
	typedef logic signed [SUM_W-1:0]       sum_t;
	typedef logic [CNT_W-1:0]              cnt_t;
	typedef logic [ALPHA_W-1:0]            alpha_t;

	// Per-item control from the top level to each channel filter.
	typedef struct packed {
		logic load;    // an item moves into the result register
		logic sample;  // the item is a sensor sample
		logic clear;   // calibration completes with this item
	} filt_ctrl_t;

endpackage

[rtl/wec_channel_filter.sv]
// ----------------------------------------------------------------------------
// wec_channel_filter
// One channel: offset subtraction and first-order Q.16 smoothing filter.
// ----------------------------------------------------------------------------
module wec_channel_filter (
	input  logic                clk,
	input  logic                arst_n,
	input  wec_pkg::filt_ctrl_t ctrl,
	input  wec_pkg::remap_t     remap,
	input  wec_pkg::ofs_t       offset,
	input  wec_pkg::alpha_t     alpha,
	output wec_pkg::out_t       result
);
	import wec_pkg::*;

	logic signed [ADJ_W-1:0]    adj;
	filt_t                      target;
	logic signed [DIFF_W-1:0]   diff;
	logic signed [ALPHA_W:0]    alpha_s;
	logic signed [PROD_W-1:0]   prod;
	logic signed [FILT_W:0]     step;
	filt_t                      upd;
	filt_t                      filt_next;
	filt_t                      filt_q;
	logic                       round_up;

	// Target value in Q.16 and its distance from the filter state.
	assign adj     = ADJ_W'(remap) - ADJ_W'(offset);
	assign target  = {adj, {FRAC_BITS{1'b0}}};
	assign diff    = DIFF_W'(target) - DIFF_W'(filt_q);
	assign alpha_s = $signed({1'b0, alpha});

	// Weighted step, floored by the arithmetic shift.
	assign prod = PROD_W'(diff) * PROD_W'(alpha_s);
	assign step = (FILT_W + 1)'(prod >>> FRAC_BITS);
	assign upd  = FILT_W'((FILT_W + 1)'(filt_q) + step);

	// A start command keeps the state; a completing sample clears it.
	always_comb begin
		if (ctrl.clear) begin
			filt_next = '0;
		end else if (ctrl.sample) begin
			filt_next = upd;
		end else begin
			filt_next = filt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (ctrl.load) begin
			filt_q <= filt_next;
		end
	end

	// Integer part truncated toward zero.
	assign round_up = filt_next[FILT_W-1] && (filt_next[FRAC_BITS-1:0] != '0);
	assign result   = filt_next[FILT_W-1:FRAC_BITS] + OUT_W'(round_up);

endmodule

[rtl/wec_offset_div.sv]
// ----------------------------------------------------------------------------
// wec_offset_div
// Signed calibration sum divided by CAL_SAMPLES, truncated toward zero.
// ----------------------------------------------------------------------------
module wec_offset_div (
	input  wec_pkg::sum_t sum,
	output wec_pkg::ofs_t quotient
);
	import wec_pkg::*;

	logic                     neg;
	logic [ABS_W-1:0]         mag;
	logic [DPROD_W-1:0]       dprod;
	logic [SAMPLE_BITS-1:0]   qmag;

	// Divide the magnitude so the result rounds toward zero.
	assign neg   = sum[SUM_W-1];
	assign mag   = neg ? ABS_W'(-sum) : ABS_W'(sum);
	assign dprod = DPROD_W'(mag) * DPROD_W'(DIV_MUL);
	assign qmag  = SAMPLE_BITS'(dprod >> DIV_SHIFT);

	assign quotient = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

endmodule

[rtl/wec_calibration.sv]
// ----------------------------------------------------------------------------
// wec_calibration
// Offset calibration: sample counting, running sums and stored offsets.
// ----------------------------------------------------------------------------
module wec_calibration (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic            start,
	input  logic            force_z_nz,
	input  wec_pkg::remap_t remap [wec_pkg::NCH],
	output wec_pkg::ofs_t   offset [wec_pkg::NCH],
	output logic            done,
	output logic            active_next
);
	import wec_pkg::*;

	sum_t  sum_q [NCH];
	sum_t  sum_inc [NCH];
	ofs_t  ofs_q [NCH];
	ofs_t  ofs_div [NCH];
	cnt_t  cnt_q;
	cnt_t  cnt_inc;
	logic  active_q;
	logic  accum;

	// A sample counts while calibrating when its raw force z carries data.
	assign accum   = active_q && !start && force_z_nz;
	assign cnt_inc = cnt_q + CNT_W'(1);
	assign done    = accum && (cnt_inc >= CNT_W'(CAL_SAMPLES));

	// Running sums and the offsets they give at completion.
	for (genvar i = 0; i < NCH; i++) begin : g_ch
		assign sum_inc[i] = sum_q[i] + SUM_W'(remap[i]);

		wec_offset_div u_div (
			.sum      (sum_inc[i]),
			.quotient (ofs_div[i])
		);

		assign offset[i] = ofs_q[i];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sum_q[i] <= '0;
				ofs_q[i] <= '0;
			end else if (load) begin
				if (start) begin
					sum_q[i] <= '0;
					ofs_q[i] <= '0;
				end else if (accum) begin
					sum_q[i] <= sum_inc[i];
					if (done) begin
						ofs_q[i] <= ofs_div[i];
					end
				end
			end
		end
	end

	// Calibration flag after the current item.
	always_comb begin
		if (start) begin
			active_next = 1'b1;
		end else if (done) begin
			active_next = 1'b0;
		end else begin
			active_next = active_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			active_q <= 1'b0;
		end else if (load) begin
			active_q <= active_next;
			if (start) begin
				cnt_q <= '0;
			end else if (accum) begin
				cnt_q <= cnt_inc;
			end
		end
	end

endmodule

[rtl/wrench_offset_ema_conditioner_top.sv]
// ----------------------------------------------------------------------------
// wrench_offset_ema_conditioner_top
// Six-axis force/torque conditioner with offset calibration and smoothing.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output side is not
// stalled and returns one result per item: an input register holds the
// remapped sample, and the offset subtraction, the 17x35 filter multiply
// and the state update are combinational from it into the result register
// and the filter state. An output register decouples the channels,
// so a new item is taken while a finished result waits. A start-calibration
// item zeroes the offsets and begins collecting CAL_SAMPLES samples with
// nonzero raw force z; the completing sample loads the offsets and clears the
// filters. The filter weight may be written only while the block is idle; a
// value above 1.0 acts as 1.0. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module wrench_offset_ema_conditioner_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  wec_pkg::alpha_t         cfg_wr_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    opcode,
	input  wec_pkg::sample_t        raw_force_x,
	input  wec_pkg::sample_t        raw_force_y,
	input  wec_pkg::sample_t        raw_force_z,
	input  wec_pkg::sample_t        raw_torque_x,
	input  wec_pkg::sample_t        raw_torque_y,
	input  wec_pkg::sample_t        raw_torque_z,
	output logic                    out_valid,
	input  logic                    out_ready,
	output wec_pkg::out_t           filt_force_x,
	output wec_pkg::out_t           filt_force_y,
	output wec_pkg::out_t           filt_force_z,
	output wec_pkg::out_t           filt_torque_x,
	output wec_pkg::out_t           filt_torque_y,
	output wec_pkg::out_t           filt_torque_z,
	output logic                    calibrating
);
	import wec_pkg::*;

	alpha_t     alpha_q;
	logic       s1_valid_q;
	logic       out_valid_q;
	logic       advance;
	logic       in_xfer;
	opcode_t    op_s1;
	logic       z_nz_s1;
	remap_t     remap_in [NCH];
	remap_t     remap_s1 [NCH];
	ofs_t       offset [NCH];
	out_t       result [NCH];
	out_t       filt_q [NCH];
	logic       cal_q;
	logic       cal_done;
	logic       cal_next;
	filt_ctrl_t ctrl;

	// Filter weight register, limited to 1.0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ONE_Q16;
		end else if (cfg_wr_en) begin
			alpha_q <= cfg_wr_data[ALPHA_W-1] ? ONE_Q16 : cfg_wr_data;
		end
	end

	// Handshake: the input stage moves on when the result register is free.
	assign advance   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready  = !s1_valid_q || advance;
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Axis remap: x takes raw y, y takes negated raw x.
	assign remap_in[CH_FX] = REMAP_W'(raw_force_y);
	assign remap_in[CH_FY] = -REMAP_W'(raw_force_x);
	assign remap_in[CH_FZ] = REMAP_W'(raw_force_z);
	assign remap_in[CH_TX] = REMAP_W'(raw_torque_y);
	assign remap_in[CH_TY] = -REMAP_W'(raw_torque_x);
	assign remap_in[CH_TZ] = REMAP_W'(raw_torque_z);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1    <= opcode_t'(opcode);
			z_nz_s1  <= (raw_force_z != '0);
			remap_s1 <= remap_in;
		end
	end

	// Calibration control and stored offsets.
	wec_calibration u_cal (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance),
		.start       (op_s1 == OP_CAL_START),
		.force_z_nz  (z_nz_s1),
		.remap       (remap_s1),
		.offset      (offset),
		.done        (cal_done),
		.active_next (cal_next)
	);

	assign ctrl.load   = advance;
	assign ctrl.sample = (op_s1 == OP_SAMPLE);
	assign ctrl.clear  = cal_done;

	// One filter per channel.
	for (genvar i = 0; i < NCH; i++) begin : g_filt
		wec_channel_filter u_filt (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.remap  (remap_s1[i]),
			.offset (offset[i]),
			.alpha  (alpha_q),
			.result (result[i])
		);
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			filt_q <= result;
			cal_q  <= cal_next;
		end
	end

	assign filt_force_x  = filt_q[CH_FX];
	assign filt_force_y  = filt_q[CH_FY];
	assign filt_force_z  = filt_q[CH_FZ];
	assign filt_torque_x = filt_q[CH_TX];
	assign filt_torque_y = filt_q[CH_TY];
	assign filt_torque_z = filt_q[CH_TZ];
	assign calibrating   = cal_q;

endmodule
